[sv/suffix_automaton_distinct_count_defines.svh]
// Assertion macros shared by the checker of the suffix automaton block.
// Depends on nothing; include by bare file name.
`ifndef SUFFIX_AUTOMATON_DISTINCT_COUNT_DEFINES_SVH
`define SUFFIX_AUTOMATON_DISTINCT_COUNT_DEFINES_SVH

// Next-cycle implication, also checked while reset is held.
`define SADC_ASSERT_NEXT(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("lbl failed");

// Next-cycle implication, off while reset is low.
`define SADC_ASSERT_NEXT_RST(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lbl failed");

// Same-cycle implication, off while reset is low.
`define SADC_ASSERT_NOW_RST(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lbl failed");

`endif

[sv/sadc_pkg.sv]
// Shared constants of the suffix automaton distinct-substring counter.
// No dependencies.
package sadc_pkg;
  localparam int MAX_LEN_DEF  = 1024;
  localparam int ALPHABET_DEF = 26;
  localparam int SYM_W        = 5;
  localparam int COUNT_W      = 20;
  localparam int IN_TDATA_W   = 8;
  localparam int OUT_TDATA_W  = 24;
endpackage

[sv/suffix_automaton_distinct_count.sv]
// Online suffix automaton over a symbol stream, one count result per symbol; uses sadc_pkg.
// Path from input transfer to out_tvalid: an ignored symbol goes straight to emit; an appended
// one reads the last length, clears its new row, then walks suffix links until a transition is
// found or root is reached, and a clone copies row q then redirects (clear and copy on one port pair).
// Throughput: one item in flight; start_req adds a root row clear.
// Reset: synchronous active low; then the root row is cleared, with in_tready low.
module suffix_automaton_distinct_count #(
  parameter int MAX_LEN  = sadc_pkg::MAX_LEN_DEF,
  parameter int ALPHABET = sadc_pkg::ALPHABET_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [sadc_pkg::IN_TDATA_W-1:0]  in_tdata,   // [4:0] symbol, [7:5] zero
  input  logic                             in_tuser,   // [0] start_req
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [sadc_pkg::OUT_TDATA_W-1:0] out_tdata,  // [19:0] distinct_count, [23:20] zero
  output logic                             out_tuser   // [0] full_res
);
  localparam int NUM_STATES = 2 * MAX_LEN;
  localparam int SW = (NUM_STATES > 2) ? $clog2(NUM_STATES) : 1;
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int KW = $clog2(ALPHABET + 1);
  localparam int TDEPTH = NUM_STATES * ALPHABET;
  localparam int TW = $clog2(TDEPTH);
  localparam int CW = sadc_pkg::COUNT_W;

  typedef enum logic [17:0] {
    ST_IDLE   = 18'h00001,
    ST_CLR    = 18'h00002,
    ST_CHECK  = 18'h00004,
    ST_A_LEN  = 18'h00008,
    ST_CLR_NP = 18'h00010,
    ST_W1_RD  = 18'h00020,
    ST_W1_CHK = 18'h00040,
    ST_W1_LNK = 18'h00080,
    ST_F_RDQ  = 18'h00100,
    ST_F_CMP  = 18'h00200,
    ST_F_LNKQ = 18'h00400,
    ST_F_LQ   = 18'h00800,
    ST_F_LNP  = 18'h01000,
    ST_CPY    = 18'h02000,
    ST_W2_RD  = 18'h04000,
    ST_W2_CHK = 18'h08000,
    ST_W2_LNK = 18'h10000,
    ST_EMIT   = 18'h20000
  } state_t;

  logic [SW-1:0] len_mem  [NUM_STATES];
  logic [SW-1:0] link_mem [NUM_STATES];
  logic [SW-1:0] tr_mem   [TDEPTH];

  state_t state_r, state_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic go_check_r, go_check_nxt;
  logic [sadc_pkg::SYM_W-1:0] c_r, c_nxt;
  logic [SW-1:0] last_r, last_nxt, nf_r, nf_nxt, np_r, np_nxt, p_r, p_nxt;
  logic [SW-1:0] q_r, q_nxt, nq_r, nq_nxt, np_len_r, np_len_nxt, lenp_r, lenp_nxt;
  logic [LW-1:0] slen_r, slen_nxt;
  logic [CW-1:0] total_r, total_nxt;
  logic full_r, full_nxt;
  logic out_valid_r;
  logic [CW-1:0] out_count_r;
  logic out_full_r;

  logic len_we, link_we, tr_we;
  logic [SW-1:0] len_wa, len_wd, len_ra, len_rd;
  logic [SW-1:0] link_wa, link_wd, link_ra, link_rd;
  logic [SW-1:0] tr_wrow, tr_rrow, tr_wd, tr_rd;
  logic [KW-1:0] tr_wcol, tr_rcol;
  logic [TW-1:0] tr_wa, tr_ra;
  logic [KW-1:0] c_col;
  logic in_xfer, emit_go;

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign emit_go   = (state_r == ST_EMIT) && (!out_valid_r || out_tready);
  assign c_col     = KW'(c_r);
  assign tr_wa = TW'(tr_wrow) * TW'(ALPHABET) + TW'(tr_wcol);
  assign tr_ra = TW'(tr_rrow) * TW'(ALPHABET) + TW'(tr_rcol);

  always_ff @(posedge clk) begin
    if (len_we) len_mem[len_wa] <= len_wd;
    len_rd <= len_mem[len_ra];
    if (link_we) link_mem[link_wa] <= link_wd;
    link_rd <= link_mem[link_ra];
    if (tr_we) tr_mem[tr_wa] <= tr_wd;
    tr_rd <= tr_mem[tr_ra];
  end

  always_comb begin
    state_nxt = state_r;     k_nxt = k_r;         go_check_nxt = go_check_r;
    c_nxt = c_r;             last_nxt = last_r;   nf_nxt = nf_r;
    np_nxt = np_r;           p_nxt = p_r;         q_nxt = q_r;
    nq_nxt = nq_r;           np_len_nxt = np_len_r;
    lenp_nxt = lenp_r;       slen_nxt = slen_r;   total_nxt = total_r;
    full_nxt = full_r;
    len_we = 1'b0;  len_wa = np_r;  len_wd = '0;  len_ra = p_r;
    link_we = 1'b0; link_wa = np_r; link_wd = '0; link_ra = p_r;
    tr_we = 1'b0;   tr_wrow = p_r;  tr_wcol = c_col; tr_wd = np_r;
    tr_rrow = p_r;  tr_rcol = c_col;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          c_nxt = in_tdata[sadc_pkg::SYM_W-1:0];
          if (in_tuser) begin
            last_nxt = '0; nf_nxt = SW'(1); slen_nxt = '0; total_nxt = '0;
            k_nxt = '0; go_check_nxt = 1'b1; state_nxt = ST_CLR;
          end else begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CLR: begin
        // root row clear; root length and link written on the first pass
        tr_we = 1'b1; tr_wrow = '0; tr_wcol = k_r; tr_wd = '0;
        len_we = (k_r == '0); len_wa = '0; len_wd = '0;
        link_we = (k_r == '0); link_wa = '0; link_wd = '0;
        k_nxt = k_r + KW'(1);
        if (k_r == KW'(ALPHABET - 1)) state_nxt = go_check_r ? ST_CHECK : ST_IDLE;
      end
      ST_CHECK: begin
        if (32'(c_r) >= ALPHABET) begin
          full_nxt = 1'b0; state_nxt = ST_EMIT;
        end else if (32'(slen_r) >= MAX_LEN) begin
          full_nxt = 1'b1; state_nxt = ST_EMIT;
        end else begin
          np_nxt = nf_r; nf_nxt = nf_r + SW'(1); p_nxt = last_r;
          len_ra = last_r; state_nxt = ST_A_LEN;
        end
      end
      ST_A_LEN: begin
        len_we = 1'b1; len_wa = np_r; len_wd = len_rd + SW'(1);
        np_len_nxt = len_rd + SW'(1);
        k_nxt = '0; state_nxt = ST_CLR_NP;
      end
      ST_CLR_NP: begin
        tr_we = 1'b1; tr_wrow = np_r; tr_wcol = k_r; tr_wd = '0;
        k_nxt = k_r + KW'(1);
        if (k_r == KW'(ALPHABET - 1)) state_nxt = ST_W1_RD;
      end
      ST_W1_RD: state_nxt = ST_W1_CHK;
      ST_W1_CHK: begin
        if (tr_rd != '0) begin
          q_nxt = tr_rd; len_ra = p_r; state_nxt = ST_F_RDQ;
        end else begin
          tr_we = 1'b1;
          if (p_r == '0) begin
            link_we = 1'b1; link_wa = np_r; link_wd = '0;
            total_nxt = total_r + CW'(np_len_r);
            last_nxt = np_r; slen_nxt = slen_r + LW'(1); full_nxt = 1'b0;
            state_nxt = ST_EMIT;
          end else begin
            link_ra = p_r; state_nxt = ST_W1_LNK;
          end
        end
      end
      ST_W1_LNK: begin
        p_nxt = link_rd; state_nxt = ST_W1_RD;
      end
      ST_F_RDQ: begin
        lenp_nxt = len_rd; len_ra = q_r; state_nxt = ST_F_CMP;
      end
      ST_F_CMP: begin
        if (lenp_r + SW'(1) == len_rd) begin
          link_we = 1'b1; link_wa = np_r; link_wd = q_r;
          total_nxt = total_r + CW'(np_len_r - len_rd);
          last_nxt = np_r; slen_nxt = slen_r + LW'(1); full_nxt = 1'b0;
          state_nxt = ST_EMIT;
        end else begin
          nq_nxt = nf_r; nf_nxt = nf_r + SW'(1);
          len_we = 1'b1; len_wa = nf_r; len_wd = lenp_r + SW'(1);
          link_ra = q_r; state_nxt = ST_F_LNKQ;
        end
      end
      ST_F_LNKQ: begin
        link_we = 1'b1; link_wa = nq_r; link_wd = link_rd; state_nxt = ST_F_LQ;
      end
      ST_F_LQ: begin
        link_we = 1'b1; link_wa = q_r; link_wd = nq_r; state_nxt = ST_F_LNP;
      end
      ST_F_LNP: begin
        link_we = 1'b1; link_wa = np_r; link_wd = nq_r;
        total_nxt = total_r + CW'(np_len_r - (lenp_r + SW'(1)));
        k_nxt = '0; state_nxt = ST_CPY;
      end
      ST_CPY: begin
        // read row q one column ahead of the write into row nq
        tr_rrow = q_r; tr_rcol = k_r;
        tr_we = (k_r != '0); tr_wrow = nq_r; tr_wcol = k_r - KW'(1); tr_wd = tr_rd;
        k_nxt = k_r + KW'(1);
        if (k_r == KW'(ALPHABET)) state_nxt = ST_W2_RD;
      end
      ST_W2_RD: state_nxt = ST_W2_CHK;
      ST_W2_CHK: begin
        if (tr_rd != q_r || p_r == '0) begin
          tr_we = (tr_rd == q_r); tr_wd = nq_r;
          last_nxt = np_r; slen_nxt = slen_r + LW'(1); full_nxt = 1'b0;
          state_nxt = ST_EMIT;
        end else begin
          tr_we = 1'b1; tr_wd = nq_r; link_ra = p_r; state_nxt = ST_W2_LNK;
        end
      end
      ST_W2_LNK: begin
        p_nxt = link_rd; state_nxt = ST_W2_RD;
      end
      ST_EMIT: begin
        if (emit_go) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;   k_r <= '0;       go_check_r <= 1'b0;
      last_r <= '0;        nf_r <= SW'(1);  slen_r <= '0;
      total_r <= '0;       out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt; k_r <= k_nxt;   go_check_r <= go_check_nxt;
      last_r <= last_nxt;   nf_r <= nf_nxt; slen_r <= slen_nxt;
      total_r <= total_nxt;
      if (emit_go) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    c_r <= c_nxt;   np_r <= np_nxt;   p_r <= p_nxt;   q_r <= q_nxt;
    nq_r <= nq_nxt; np_len_r <= np_len_nxt; lenp_r <= lenp_nxt; full_r <= full_nxt;
    if (emit_go) begin
      out_count_r <= total_r;
      out_full_r  <= full_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(sadc_pkg::OUT_TDATA_W - CW)'(0), out_count_r};
  assign out_tuser  = out_full_r;
endmodule

[sv/sadc_checker.sv]
// Port-level checker for suffix_automaton_distinct_count, bound to the top level.
// Uses sadc_pkg and the assertion macros header.
`include "suffix_automaton_distinct_count_defines.svh"
module sadc_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [sadc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tuser
);
  `SADC_ASSERT_NEXT(a_reset_clears_out, clk, !rst_n, !out_tvalid && !in_tready)
  `SADC_ASSERT_NEXT_RST(a_one_in_flight, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `SADC_ASSERT_NEXT_RST(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))
  `SADC_ASSERT_NOW_RST(a_pad_zero, clk, rst_n, out_tvalid, out_tdata[sadc_pkg::OUT_TDATA_W-1:sadc_pkg::COUNT_W] == '0)
endmodule

bind suffix_automaton_distinct_count sadc_checker u_sadc_checker (.*);

[tb/suffix_automaton_distinct_count_tb.sv]
// Self-checking testbench for the suffix automaton distinct-substring counter.
// Directed table then random symbol runs, checked against an in-bench automaton.
// Depends on sadc_pkg and suffix_automaton_distinct_count.
`timescale 1ns / 100ps

module suffix_automaton_distinct_count_tb;

  localparam int NSTATES = 2 * sadc_pkg::MAX_LEN_DEF;
  localparam int ALPHA = sadc_pkg::ALPHABET_DEF;
  localparam int SYM_W = sadc_pkg::SYM_W;
  localparam int COUNT_W = sadc_pkg::COUNT_W;
  localparam int IN_TDATA_W = sadc_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = sadc_pkg::OUT_TDATA_W;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               full;
  } count_result_t;

  typedef struct {
    logic [SYM_W-1:0]   sym;
    logic               start;
    bit                 typed;
    logic [COUNT_W-1:0] count;
    logic               full;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tuser;

  suffix_automaton_distinct_count uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  // automaton copy
  int unsigned sa_len [NSTATES];
  int unsigned sa_link[NSTATES];
  int unsigned sa_next[NSTATES][ALPHA];
  int unsigned sa_last, sa_free, sa_strlen;
  longint unsigned sa_total;

  count_result_t pending_counts[$];
  stim_row_t     typed_rows[$];
  stim_row_t     stim[$];
  int errors = 0;
  int accepted = 0;
  int results_seen = 0;
  int full_seen = 0;
  int clones = 0;
  bit quiet = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("timeout: %0d results outstanding", pending_counts.size());
    $display("*** FAILED ***");
    $finish;
  end

  function automatic void clear_automaton();
    sa_len[0] = 0;
    sa_link[0] = 0;
    for (int k = 0; k < ALPHA; k++) sa_next[0][k] = 0;
    sa_last = 0;
    sa_free = 1;
    sa_strlen = 0;
    sa_total = 0;
  endfunction

  function automatic void extend_automaton(input int unsigned c, output count_result_t r);
    int unsigned np, p, q, nq;
    bit found;
    np = sa_free++;
    p = sa_last;
    found = 1'b0;
    sa_len[np] = sa_len[p] + 1;
    for (int k = 0; k < ALPHA; k++) sa_next[np][k] = 0;
    forever begin
      if (sa_next[p][c] != 0) begin
        found = 1'b1;
        break;
      end
      sa_next[p][c] = np;
      if (p == 0) break;
      p = sa_link[p];
    end
    if (!found) begin
      sa_link[np] = 0;
    end else begin
      q = sa_next[p][c];
      if (sa_len[p] + 1 == sa_len[q]) begin
        sa_link[np] = q;
      end else begin
        clones++;
        nq = sa_free++;
        sa_len[nq] = sa_len[p] + 1;
        for (int k = 0; k < ALPHA; k++) sa_next[nq][k] = sa_next[q][k];
        sa_link[nq] = sa_link[q];
        sa_link[q] = nq;
        sa_link[np] = nq;
        forever begin
          if (sa_next[p][c] != q) break;
          sa_next[p][c] = nq;
          if (p == 0) break;
          p = sa_link[p];
        end
      end
    end
    sa_total += sa_len[np] - sa_len[sa_link[np]];
    sa_last = np;
    sa_strlen++;
    r.count = sa_total[COUNT_W-1:0];
    r.full = 1'b0;
  endfunction

  function automatic count_result_t predict_count(logic [SYM_W-1:0] sym, logic start);
    count_result_t r;
    if (start) clear_automaton();
    r.count = sa_total[COUNT_W-1:0];
    r.full = 1'b0;
    if (sym >= ALPHA) return r;
    if (sa_strlen >= sadc_pkg::MAX_LEN_DEF) begin
      r.full = 1'b1;
      return r;
    end
    extend_automaton(32'(sym), r);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("mismatch at result %0d: %s got %0d want %0d", results_seen, what, got, want);
  endtask

  // predict on every accepted input transfer
  always @(posedge clk) begin
    count_result_t r;
    stim_row_t row;
    if (rst_n && in_tvalid && in_tready) begin
      r = predict_count(in_tdata[SYM_W-1:0], in_tuser);
      row = typed_rows.pop_front();
      if (row.typed) begin
        r.count = row.count;
        r.full = row.full;
      end
      pending_counts.push_back(r);
      accepted++;
    end
  end

  always @(posedge clk) begin
    count_result_t w;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_counts.size() == 0) begin
        report_mismatch("unexpected result, count", int'(out_tdata[COUNT_W-1:0]), 0);
      end else begin
        w = pending_counts.pop_front();
        if (out_tdata[COUNT_W-1:0] !== w.count)
          report_mismatch("distinct_count", int'(out_tdata[COUNT_W-1:0]), int'(w.count));
        if (out_tuser !== w.full) report_mismatch("full_res", int'(out_tuser), int'(w.full));
        if (w.full) full_seen++;
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    out_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 38);
  end

  task automatic add_row(input int sym, input bit start, input bit typed = 0,
                         input int count = 0, input bit full = 0);
    stim_row_t row;
    row.sym = sym[SYM_W-1:0];
    row.start = start;
    row.typed = typed;
    row.count = count[COUNT_W-1:0];
    row.full = full;
    stim.push_back(row);
  endtask

  task automatic add_run(input int len, input int top);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 4) add_row($urandom_range(31, ALPHA), 1'b0);
      else add_row($urandom_range(top), i == 0);
    end
  endtask

  initial begin
    stim_row_t row;
    int n;
    // directed: first symbol after reset, out-of-range symbol, start requests
    add_row(0, 0, 1, 1, 0);
    add_row(31, 0, 1, 1, 0);
    add_row(25, 1, 1, 1, 0);
    add_row(0, 1, 1, 1, 0);
    add_row(0, 0, 1, 2, 0);
    add_row(26, 1, 1, 0, 0);
    add_row(1, 0);
    add_row(1, 0);
    add_row(0, 0);
    add_row(1, 0);
    add_row(2, 0);
    add_row(1, 0);
    add_row(2, 0);
    add_row(1, 1);
    add_row(0, 0);
    add_row(1, 0);
    add_row(30, 0);
    add_row(0, 0);
    // random: one long run of MAX_LEN_DEF + 12 symbols, then short runs
    add_run(sadc_pkg::MAX_LEN_DEF + 12, 2);
    while (stim.size() < 1300) begin
      n = $urandom_range(99) < 80 ? $urandom_range(40, 1) : $urandom_range(200, 40);
      add_run(n, $urandom_range(99) < 70 ? $urandom_range(3, 1) : ALPHA - 1);
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < stim.size(); i++) begin
      row = stim[i];
      quiet = (i >= 300 && i < 500);
      if (!quiet && $urandom_range(99) < 38) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        while ($urandom_range(99) < 38) @(posedge clk);
      end
      typed_rows.push_back(row);
      in_tvalid <= 1'b1;
      in_tdata <= {{(IN_TDATA_W-SYM_W){1'b0}}, row.sym};
      in_tuser <= row.start;
      @(posedge clk);
      while (!in_tready) @(posedge clk);
    end
    in_tvalid <= 1'b0;
    quiet = 1'b0;

    while (pending_counts.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d symbols, %0d results, %0d clones, %0d full-string results",
             accepted, results_seen, clones, full_seen);
    $display("mismatches: %0d", errors);
    if (errors == 0 && pending_counts.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
